[hw/rtl/spp_pkg.sv]
// Shared types, constants and helper functions for the stereo point projection unit.
// Every other file of the unit imports this package; it depends on nothing else.
`timescale 1ns / 1ps
package spp_pkg;

    // Build-time choices.
    localparam int NUM_CAMERAS = 2;
    localparam int WORD_BITS   = 32;

    // Effective word size of inputs, coefficients and saturated results.
    localparam int EFF_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;

    // Field widths.
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 5;
    localparam int OUT_CAMS   = 2;
    localparam int COEF_DEPTH = NUM_CAMERAS * 12;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);

    // Stream word layout.
    localparam int IN_BITS   = IDX_W + 7 * VAL_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8 * VAL_W;
    localparam int M_TUSER_W = OUT_CAMS;

    // Datapath widths.
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int H_W       = SUM_W - FRAC_BITS - 1;
    localparam int SPLIT     = 24;
    localparam int HI_W      = H_W - SPLIT;
    localparam int LL_W      = 2 * SPLIT;
    localparam int PP_W      = 2 * (HI_W > SPLIT + 1 ? HI_W : SPLIT + 1);
    localparam int TN_W      = 2 * H_W + 1;
    localparam int NUM_W     = TN_W - 1;
    localparam int DEN_W     = 2 * H_W - 1;
    localparam int Q_W       = 32;
    localparam int REM_W     = DEN_W + Q_W;

    // Pipeline depths: four arithmetic stages, then the divider.
    localparam int DIV_STAGES  = Q_W + 2;
    localparam int BACK_STAGES = 4 + DIV_STAGES;
    localparam int DEG_FIRST   = 2;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Saturation limit for the positive side.
    localparam logic [Q_W:0] MAXPOS = ((Q_W + 1)'(1) << (EFF_BITS - 1)) - (Q_W + 1)'(1);

    // Command codes.
    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PROJECT = 1'b1
    } cmd_t;

    // One queued command.
    typedef struct packed {
        logic                        is_load;
        logic [IDX_W-1:0]            coef_idx;
        logic [VAL_W-1:0]            coef_val;
        logic [2:0][VAL_W-1:0]       pt;
        logic [2:0][VAL_W-1:0]       dr;
    } q_entry_t;

    // Sign extend from the effective word size.
    function automatic logic [VAL_W-1:0] sext_word(logic [VAL_W-1:0] x);
        logic signed [VAL_W-1:0] t;
        t = $signed(x) <<< (VAL_W - EFF_BITS);
        return t >>> (VAL_W - EFF_BITS);
    endfunction

    // Saturate a quotient magnitude and apply its sign.
    function automatic logic [Q_W-1:0] sat_q(logic [Q_W-1:0] q, logic ovf, logic neg);
        logic [Q_W:0] qq;
        logic [Q_W:0] lim;
        qq  = ovf ? {1'b0, {Q_W{1'b1}}} : {1'b0, q};
        lim = neg ? MAXPOS + (Q_W + 1)'(1) : MAXPOS;
        if (qq > lim) begin
            qq = lim;
        end
        if (neg) begin
            qq = (Q_W + 1)'(0) - qq;
        end
        return qq[Q_W-1:0];
    endfunction

endpackage

[hw/rtl/spp_front.sv]
// Input side of the projection unit: unpacks the stream word and classifies the command.
// Depends on spp_pkg; feeds spp_queue.
`timescale 1ns / 1ps
module spp_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spp_pkg::S_TDATA_W-1:0] s_tdata,   // coef_index, coef_value, point_x/y/z, dir_x/y/z
    input  logic [0:0]                    s_tuser,   // command
    input  logic                          q_full_i,
    output logic                          push_o,
    output spp_pkg::q_entry_t             entry_o
);
    import spp_pkg::*;

    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic             keep;

    // Decode the word.
    always_comb begin
        cmd = cmd_t'(s_tuser[0]);
        idx = s_tdata[IDX_W-1:0];
        entry_o.is_load  = (cmd == CMD_LOAD);
        entry_o.coef_idx = idx;
        entry_o.coef_val = s_tdata[IDX_W +: VAL_W];
        for (int i = 0; i < 3; i++) begin
            entry_o.pt[i] = sext_word(s_tdata[IDX_W + (1 + i) * VAL_W +: VAL_W]);
            entry_o.dr[i] = sext_word(s_tdata[IDX_W + (4 + i) * VAL_W +: VAL_W]);
        end
        // Loads outside the coefficient store are dropped here.
        keep = (cmd == CMD_PROJECT) || (32'(idx) < COEF_DEPTH);
    end

    assign s_tready = !q_full_i;
    assign push_o   = s_tvalid && s_tready && keep;

endmodule

[hw/rtl/spp_queue.sv]
// Short command queue between the front and back parts of the projection unit.
// Depends on spp_pkg.
`timescale 1ns / 1ps
module spp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  spp_pkg::q_entry_t entry_i,
    output logic              full_o,
    input  logic              pop_i,
    output spp_pkg::q_entry_t entry_o,
    output logic              empty_o
);
    import spp_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full_o  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty_o = (cnt_reg == '0);
    assign entry_o = mem_reg[rd_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push_i) begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop_i) begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push_i && !pop_i) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_reg] <= entry_i;
        end
    end

endmodule

[hw/rtl/spp_div.sv]
// Pipelined restoring divider: saturated (num * 2^16) / den, one quotient bit per stage.
// Depends on spp_pkg.
`timescale 1ns / 1ps
module spp_div (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [spp_pkg::NUM_W-1:0] num_i,
    input  logic [spp_pkg::DEN_W-1:0] den_i,
    input  logic                      neg_i,
    output logic [spp_pkg::Q_W-1:0]   q_o
);
    import spp_pkg::*;

    logic [NUM_W-1:0] n0_reg;
    logic [DEN_W-1:0] d0_reg;
    logic             neg0_reg;

    logic [REM_W-1:0] rem_reg [Q_W+1];
    logic [DEN_W-1:0] dv_reg  [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic             neg_reg [Q_W+1];
    logic             ovf_reg [Q_W+1];

    // Input register.
    always_ff @(posedge aclk) begin
        if (en) begin
            n0_reg   <= num_i;
            d0_reg   <= den_i;
            neg0_reg <= neg_i;
        end
    end

    // Overflow check: the quotient would not fit the word.
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= (REM_W'(n0_reg) << FRAC_BITS) >= (REM_W'(d0_reg) << Q_W);
            rem_reg[0] <= REM_W'(n0_reg) << FRAC_BITS;
            dv_reg[0]  <= d0_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg0_reg;
        end
    end

    // One restoring step per stage, most significant bit first.
    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             fits;
        assign trial = REM_W'(dv_reg[k-1]) << (Q_W - k);
        assign fits  = rem_reg[k-1] >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= fits ? rem_reg[k-1] - trial : rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (fits ? (Q_W'(1) << (Q_W - k)) : '0);
                dv_reg[k]  <= dv_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign q_o = sat_q(q_reg[Q_W], ovf_reg[Q_W], neg_reg[Q_W]);

endmodule

[hw/rtl/spp_camera.sv]
// Projection datapath for one camera: homogeneous products, tangent numerators and four divides.
// Depends on spp_pkg and spp_div.
`timescale 1ns / 1ps
module spp_camera (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [11:0][spp_pkg::VAL_W-1:0]   coef_i,
    input  logic [2:0][spp_pkg::VAL_W-1:0]    pt_i,
    input  logic [2:0][spp_pkg::VAL_W-1:0]    dr_i,
    output logic                              deg_o,
    output logic [3:0][spp_pkg::VAL_W-1:0]    res_o
);
    import spp_pkg::*;

    logic signed [PROD_W-1:0] pp_reg [3][3];
    logic signed [PROD_W-1:0] pd_reg [3][3];
    logic signed [VAL_W-1:0]  k3_reg [3];

    logic signed [SUM_W-1:0]  s_sum [3];
    logic signed [SUM_W-1:0]  t_sum [3];
    logic signed [H_W-1:0]    h_reg [3];
    logic signed [H_W-1:0]    d_reg [3];

    logic signed [H_W-1:0]    ma [5];
    logic signed [H_W-1:0]    mb [5];
    logic [LL_W-1:0]          ll_reg [5];
    logic signed [PP_W-1:0]   lh_reg [5];
    logic signed [PP_W-1:0]   hl_reg [5];
    logic signed [PP_W-1:0]   hh_reg [5];
    logic signed [H_W-1:0]    h3_reg [3];

    logic signed [TN_W-1:0]   full [5];
    logic signed [TN_W-1:0]   tnu_reg;
    logic signed [TN_W-1:0]   tnv_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic signed [H_W-1:0]    h4_reg [3];

    logic [H_W-1:0]           mag_u, mag_v, mag_w;
    logic [TN_W-1:0]          mag_tu, mag_tv;

    // Stage 1: coefficient times coordinate, one multiplier per term.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pp_reg[r][c] <= $signed(coef_i[r*4+c]) * $signed(pt_i[c]);
                    pd_reg[r][c] <= $signed(coef_i[r*4+c]) * $signed(dr_i[c]);
                end
                k3_reg[r] <= $signed(coef_i[r*4+3]);
            end
        end
    end

    // Stage 2: row sums, floored back to Q.16.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s_sum[r] = SUM_W'(pp_reg[r][0]) + SUM_W'(pp_reg[r][1]) + SUM_W'(pp_reg[r][2])
                     + (SUM_W'(k3_reg[r]) <<< FRAC_BITS);
            t_sum[r] = SUM_W'(pd_reg[r][0]) + SUM_W'(pd_reg[r][1]) + SUM_W'(pd_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                h_reg[r] <= H_W'(s_sum[r] >>> FRAC_BITS);
                d_reg[r] <= H_W'(t_sum[r] >>> FRAC_BITS);
            end
        end
    end

    assign deg_o = (h_reg[2] == '0);

    // Stage 3: partial products of w*du, u*dw, w*dv, v*dw and w*w.
    always_comb begin
        ma[0] = h_reg[2]; mb[0] = d_reg[0];
        ma[1] = h_reg[0]; mb[1] = d_reg[2];
        ma[2] = h_reg[2]; mb[2] = d_reg[1];
        ma[3] = h_reg[1]; mb[3] = d_reg[2];
        ma[4] = h_reg[2]; mb[4] = h_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int m = 0; m < 5; m++) begin
                ll_reg[m] <= ma[m][SPLIT-1:0] * mb[m][SPLIT-1:0];
                lh_reg[m] <= $signed({1'b0, ma[m][SPLIT-1:0]}) * $signed(mb[m][H_W-1:SPLIT]);
                hl_reg[m] <= $signed(ma[m][H_W-1:SPLIT]) * $signed({1'b0, mb[m][SPLIT-1:0]});
                hh_reg[m] <= $signed(ma[m][H_W-1:SPLIT]) * $signed(mb[m][H_W-1:SPLIT]);
            end
            h3_reg <= h_reg;
        end
    end

    // Stage 4: recombine the partials and form the tangent numerators.
    always_comb begin
        for (int m = 0; m < 5; m++) begin
            full[m] = (TN_W'(hh_reg[m]) <<< (2 * SPLIT))
                    + ((TN_W'(lh_reg[m]) + TN_W'(hl_reg[m])) <<< SPLIT)
                    + $signed(TN_W'(ll_reg[m]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tnu_reg  <= full[0] - full[1];
            tnv_reg  <= full[2] - full[3];
            den2_reg <= DEN_W'(full[4]);
            h4_reg   <= h3_reg;
        end
    end

    // Magnitudes for the dividers.
    always_comb begin
        mag_u  = h4_reg[0][H_W-1] ? H_W'(-h4_reg[0]) : H_W'(h4_reg[0]);
        mag_v  = h4_reg[1][H_W-1] ? H_W'(-h4_reg[1]) : H_W'(h4_reg[1]);
        mag_w  = h4_reg[2][H_W-1] ? H_W'(-h4_reg[2]) : H_W'(h4_reg[2]);
        mag_tu = tnu_reg[TN_W-1] ? TN_W'(-tnu_reg) : TN_W'(tnu_reg);
        mag_tv = tnv_reg[TN_W-1] ? TN_W'(-tnv_reg) : TN_W'(tnv_reg);
    end

    spp_div u_div_u (
        .aclk (aclk), .en (en),
        .num_i (NUM_W'(mag_u)), .den_i (DEN_W'(mag_w)),
        .neg_i (h4_reg[0][H_W-1] ^ h4_reg[2][H_W-1]), .q_o (res_o[0])
    );

    spp_div u_div_v (
        .aclk (aclk), .en (en),
        .num_i (NUM_W'(mag_v)), .den_i (DEN_W'(mag_w)),
        .neg_i (h4_reg[1][H_W-1] ^ h4_reg[2][H_W-1]), .q_o (res_o[1])
    );

    spp_div u_div_du (
        .aclk (aclk), .en (en),
        .num_i (mag_tu[NUM_W-1:0]), .den_i (den2_reg),
        .neg_i (tnu_reg[TN_W-1]), .q_o (res_o[2])
    );

    spp_div u_div_dv (
        .aclk (aclk), .en (en),
        .num_i (mag_tv[NUM_W-1:0]), .den_i (den2_reg),
        .neg_i (tnv_reg[TN_W-1]), .q_o (res_o[3])
    );

endmodule

[hw/rtl/spp_back.sv]
// Back part of the projection unit: coefficient store, camera pipelines and output register.
// Depends on spp_pkg and spp_camera.
`timescale 1ns / 1ps
module spp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spp_pkg::q_entry_t             entry_i,
    input  logic                          empty_i,
    output logic                          pop_o,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [spp_pkg::M_TUSER_W-1:0] m_tuser
);
    import spp_pkg::*;

    logic [VAL_W-1:0]                   coef_reg [COEF_DEPTH];
    logic                               adv;
    logic [BACK_STAGES-1:0]             valid_reg, valid_next;
    logic [OUT_CAMS-1:0]                deg_reg [DEG_FIRST:BACK_STAGES-1];
    logic [OUT_CAMS-1:0]                cam_deg;
    logic [OUT_CAMS-1:0][3:0][VAL_W-1:0] cam_res;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]               m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]               m_tuser_reg;
    logic [OUT_CAMS-1:0][3:0][VAL_W-1:0] res_z;

    // The whole pipeline moves when the output register can take a word.
    assign adv   = !m_tvalid_reg || m_tready;
    assign pop_o = adv && !empty_i;

    // Loads are applied in queue order, so later projections see them.
    always_ff @(posedge aclk) begin
        if (pop_o && entry_i.is_load) begin
            coef_reg[entry_i.coef_idx[COEF_AW-1:0]] <= entry_i.coef_val;
        end
    end

    // Per-camera datapaths; a camera without a matrix is always degenerate.
    for (genvar cam = 0; cam < OUT_CAMS; cam++) begin : g_cam
        if (cam < NUM_CAMERAS) begin : g_on
            logic [11:0][VAL_W-1:0] cf;
            always_comb begin
                for (int j = 0; j < 12; j++) begin
                    cf[j] = sext_word(coef_reg[cam*12+j]);
                end
            end
            spp_camera u_camera (
                .aclk   (aclk),
                .en     (adv),
                .coef_i (cf),
                .pt_i   (entry_i.pt),
                .dr_i   (entry_i.dr),
                .deg_o  (cam_deg[cam]),
                .res_o  (cam_res[cam])
            );
        end else begin : g_off
            assign cam_deg[cam] = 1'b1;
            assign cam_res[cam] = '0;
        end
    end

    // Valid bits follow each word through the pipeline.
    always_comb begin
        valid_next = {valid_reg[BACK_STAGES-2:0], pop_o && !entry_i.is_load};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Degenerate flags ride alongside from the row-sum stage on.
    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_reg[DEG_FIRST] <= cam_deg;
            for (int k = DEG_FIRST + 1; k < BACK_STAGES; k++) begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    // Output word: degenerate cameras report zero values.
    always_comb begin
        for (int c = 0; c < OUT_CAMS; c++) begin
            res_z[c] = deg_reg[BACK_STAGES-1][c] ? '0 : cam_res[c];
        end
        m_tdata_next = {res_z[1][3], res_z[1][2], res_z[0][3], res_z[0][2],
                        res_z[1][1], res_z[1][0], res_z[0][1], res_z[0][0]};
        m_tvalid_next = adv ? valid_reg[BACK_STAGES-1] : m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= deg_reg[BACK_STAGES-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A degenerate left camera gives zero left values.
    a_left_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |->
            (m_tdata_reg[63:0] == '0) && (m_tdata_reg[191:128] == '0))
        else $error("left degenerate word carries non-zero values");

    // A degenerate right camera gives zero right values.
    a_right_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[1] |->
            (m_tdata_reg[127:64] == '0) && (m_tdata_reg[255:192] == '0))
        else $error("right degenerate word carries non-zero values");

    // A stall freezes the valid pattern of the pipeline.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

endmodule

[hw/rtl/stereo_point_projection_unit.sv]
// Stereo point projection unit: two 3x4 camera matrices, image point and tangent per camera.
// Depends on spp_pkg, spp_front, spp_queue and spp_back.
//
// A word with tuser = 0 loads one matrix coefficient (index camera*12 + row*4 + column,
// out-of-range indexes are dropped); a word with tuser = 1 projects a point and a
// direction through both matrices and yields one result word. Loads and projections are
// handled strictly in order, so a projection always sees every load sent before it.
// Every coefficient must be loaded before the first projection. The unit takes one word
// per clock cycle while the queue has room and delivers one result word per cycle while
// the output is not held. A result word passes through the queue, the four arithmetic
// stages, the divider's input and range-check stages, its 32 restoring stages (one
// quotient bit per stage) and the output register. A four-entry queue separates the
// input from the pipeline, and a held output word stalls the whole pipeline.
`timescale 1ns / 1ps
module stereo_point_projection_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spp_pkg::S_TDATA_W-1:0] s_tdata,   // coef_index, coef_value, point_x,
                                                     // point_y, point_z, dir_x, dir_y, dir_z
    input  logic [0:0]                    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spp_pkg::M_TDATA_W-1:0] m_tdata,   // left_u, left_v, right_u, right_v,
                                                     // left_du, left_dv, right_du, right_dv
    output logic [spp_pkg::M_TUSER_W-1:0] m_tuser    // left_degenerate, right_degenerate
);
    import spp_pkg::*;

    q_entry_t push_entry;
    q_entry_t head_entry;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    // Decode and classify incoming words.
    spp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full_i (q_full),
        .push_o   (push),
        .entry_o  (push_entry)
    );

    // Command queue.
    spp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .entry_i (push_entry),
        .full_o  (q_full),
        .pop_i   (pop),
        .entry_o (head_entry),
        .empty_o (q_empty)
    );

    // Arithmetic pipeline and output register.
    spp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entry_i  (head_entry),
        .empty_i  (q_empty),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[verif/stereo_point_projection_checker.sv]
// Checker for the stereo point projection unit: mirrors the coefficient store,
// predicts each projection result and compares it with the output stream.
// Depends on spp_pkg for the stream widths and the command codes.
`timescale 1ns / 1ps
module stereo_point_projection_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [spp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [spp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [spp_pkg::M_TUSER_W-1:0] m_tuser,
    output int                            errors,
    output int                            pending
);
    import spp_pkg::*;

    typedef logic signed [127:0] wide_t;

    // One camera's image point, tangent and degenerate flag.
    typedef struct {
        logic [31:0] vals[4];
        logic        deg;
    } cam_view_t;

    logic [31:0]  coef_mirror[COEF_DEPTH];
    logic [257:0] projections_due[$];

    initial errors = 0;
    assign pending = projections_due.size();

    // Quotient (num * 2^16) / den truncated toward zero, then saturated to 32 bits.
    function automatic logic [31:0] sat_quotient(logic [191:0] num, logic [191:0] den,
                                                 logic neg);
        logic [191:0] q;
        q = (num << 16) / den;
        if (neg) begin
            if (q > 192'h8000_0000) q = 192'h8000_0000;
            return 32'(192'd0 - q);
        end
        if (q > 192'h7FFF_FFFF) q = 192'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic [191:0] magnitude(wide_t a);
        return (a < 0) ? 192'(-a) : 192'(a);
    endfunction

    // Project a point and a direction through one camera's matrix.
    function automatic cam_view_t view_through(int cam, wide_t pt[3], wide_t dr[3]);
        cam_view_t res;
        wide_t     hom[3], dhom[3], s, t, k, tn;
        int        base;
        for (int i = 0; i < 4; i++) res.vals[i] = '0;
        res.deg = 1'b1;
        for (int r = 0; r < 3; r++) begin
            base = cam * 12 + r * 4;
            s = 0;
            t = 0;
            for (int c = 0; c < 3; c++) begin
                k = $signed(coef_mirror[base + c]);
                s = s + k * pt[c];
                t = t + k * dr[c];
            end
            k = $signed(coef_mirror[base + 3]);
            s = s + (k <<< 16);
            hom[r]  = s >>> 16;
            dhom[r] = t >>> 16;
        end
        if (hom[2] == 0) return res;
        res.deg = 1'b0;
        for (int r = 0; r < 2; r++) begin
            res.vals[r] = sat_quotient(magnitude(hom[r]), magnitude(hom[2]),
                                       (hom[r] < 0) != (hom[2] < 0));
            tn = hom[2] * dhom[r] - hom[r] * dhom[2];
            res.vals[2 + r] = sat_quotient(magnitude(tn), magnitude(hom[2] * hom[2]),
                                           tn < 0);
        end
        return res;
    endfunction

    // Track loads and predict each accepted projection word.
    always @(posedge aclk) begin
        wide_t       pt[3], dr[3];
        cam_view_t   lv, rv;
        logic [4:0]  idx;
        if (aresetn && s_tvalid && s_tready) begin
            idx = s_tdata[4:0];
            if (s_tuser[0] == CMD_LOAD) begin
                if (idx < COEF_DEPTH) coef_mirror[idx] = s_tdata[36:5];
            end else begin
                for (int i = 0; i < 3; i++) begin
                    pt[i] = $signed(s_tdata[37 + 32 * i +: 32]);
                    dr[i] = $signed(s_tdata[133 + 32 * i +: 32]);
                end
                lv = view_through(0, pt, dr);
                rv = view_through(1, pt, dr);
                projections_due.push_back({rv.deg, lv.deg,
                    rv.vals[3], rv.vals[2], lv.vals[3], lv.vals[2],
                    rv.vals[1], rv.vals[0], lv.vals[1], lv.vals[0]});
            end
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        string       names[10];
        logic [257:0] due;
        logic [257:0] got;
        names = '{"left_u", "left_v", "right_u", "right_v", "left_du", "left_dv",
                  "right_du", "right_dv", "left_degenerate", "right_degenerate"};
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (projections_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
            end else begin
                due = projections_due.pop_front();
                for (int f = 0; f < 10; f++) begin
                    if ((f < 8 && due[32 * f +: 32] != got[32 * f +: 32]) ||
                        (f >= 8 && due[248 + f] != got[248 + f])) begin
                        errors++;
                        if (errors <= 10) begin
                            if (f < 8) $display("%s: expected %h, got %h", names[f],
                                                due[32 * f +: 32], got[32 * f +: 32]);
                            else $display("%s: expected %b, got %b", names[f],
                                          due[248 + f], got[248 + f]);
                        end
                    end
                end
            end
        end
    end
endmodule

[verif/stereo_point_projection_unit_tb.sv]
// Testbench top for the stereo point projection unit: drives loads and projections
// with random idling and stalls, and reports the checker's verdict.
// Depends on spp_pkg, stereo_point_projection_unit and stereo_point_projection_checker.
`timescale 1ns / 1ps
module stereo_point_projection_unit_tb;
    import spp_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    int                     errors, pending;
    int                     send_idle_pct = 0, recv_stall_pct = 0;
    int                     hold_requests = 0;
    int                     quiet_cycles = 0;

    stereo_point_projection_unit dut (.*);
    stereo_point_projection_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        int hold_seen, hold_left;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= 5000) begin
            $display("stereo_point_projection_unit_tb: errors");
            $finish;
        end
    end

    // Offer one word, idling first at random; returns at the falling edge after acceptance.
    task automatic offer_word(cmd_t cmd, logic [4:0] idx, logic [31:0] val,
                              logic [31:0] pt[3], logic [31:0] dr[3]);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({dr[2], dr[1], dr[0], pt[2], pt[1], pt[0], val, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_coef(logic [4:0] idx, logic [31:0] val);
        logic [31:0] junk[3];
        for (int i = 0; i < 3; i++) junk[i] = $urandom;
        offer_word(CMD_LOAD, idx, val, junk, junk);
    endtask

    task automatic project(logic [31:0] pt[3], logic [31:0] dr[3]);
        offer_word(CMD_PROJECT, 5'($urandom), $urandom, pt, dr);
    endtask

    // A Q16.16 word: mostly moderate values, sometimes extremes or fully random.
    function automatic logic [31:0] pick_word();
        logic [31:0] edges[5];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
        case ($urandom_range(9))
            0:       return edges[$urandom_range(4)];
            1, 2:    return $urandom;
            default: return 32'($signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000);
        endcase
    endfunction

    // Sensible matrix: w row gets a firm offset so most points are not degenerate.
    task automatic load_matrices();
        for (int i = 0; i < COEF_DEPTH; i++)
            load_coef(5'(i), (i % 12 == 11) ? 32'h000A_0000 + $urandom_range(32'hFFFF)
                                            : pick_word());
    endtask

    task automatic random_phase(int count);
        logic [31:0] pt[3], dr[3];
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(49))
                0: load_coef(5'($urandom_range(31)), pick_word());
                1: begin
                    // Zero one camera's w row so its projection is degenerate.
                    for (int c = 0; c < 4; c++)
                        load_coef(5'($urandom_range(1) * 12 + 8 + c), 32'h0);
                end
                2: load_matrices();
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        pt[i] = pick_word();
                        dr[i] = pick_word();
                    end
                    project(pt, dr);
                end
            endcase
        end
    endtask

    initial begin
        logic [31:0] pt[3], dr[3];
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extreme coefficients, extreme points, degenerate and missing rows.
        for (int i = 0; i < COEF_DEPTH; i++)
            load_coef(5'(i), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
        load_coef(5'd24, 32'h1234_5678);
        load_coef(5'd31, 32'hFFFF_FFFF);
        pt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        dr = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        project(pt, dr);
        pt = '{32'h0, 32'h0, 32'h0};
        project(pt, pt);
        load_matrices();
        pt = '{32'h0002_0000, 32'hFFFE_0000, 32'h0010_0000};
        dr = '{32'h0001_0000, 32'h0, 32'hFFFF_0000};
        project(pt, dr);
        for (int c = 0; c < 4; c++) load_coef(5'(8 + c), 32'h0);
        project(pt, dr);
        for (int c = 0; c < 4; c++) load_coef(5'(20 + c), 32'h0);
        project(pt, dr);
        load_matrices();

        // Random: three idling profiles.
        send_idle_pct = 12; recv_stall_pct = 57;
        random_phase(360);
        // Long receiver hold-off while words keep coming, then drain fully.
        hold_requests++;
        random_phase(60);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        send_idle_pct = 57; recv_stall_pct = 12;
        random_phase(320);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_phase(360);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (errors == 0) $display("stereo_point_projection_unit_tb: clean");
        else $display("stereo_point_projection_unit_tb: errors");
        $finish;
    end
endmodule

[stereo_point_projection_unit.f]
hw/rtl/spp_pkg.sv
hw/rtl/spp_front.sv
hw/rtl/spp_queue.sv
hw/rtl/spp_div.sv
hw/rtl/spp_camera.sv
hw/rtl/spp_back.sv
hw/rtl/stereo_point_projection_unit.sv
verif/stereo_point_projection_checker.sv
verif/stereo_point_projection_unit_tb.sv
